@@ sv/dssm_pkg.sv @@
// ============================================================================
// dssm_pkg
// Shared types and constants for the dual stack shared memory core.
// ============================================================================
`default_nettype none

package dssm_pkg;

  // Number of words in the shared store.
  localparam int DEPTH_C = 16;

  // Widths; ADDR_W and CNT_W are derived from the depth.
  localparam int ADDR_W = (DEPTH_C > 1) ? $clog2(DEPTH_C) : 1;
  localparam int CNT_W  = $clog2(DEPTH_C + 1);
  localparam int DATA_W = 32;
  localparam int FREE_W = 5;

  // Operation codes.
  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // Stack selector codes.
  localparam logic [1:0] SEL_LOWER = 2'd1;
  localparam logic [1:0] SEL_UPPER = 2'd2;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  // Request from the controller to the store.
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } mem_req_t;

endpackage

`default_nettype wire

@@ sv/dssm_ram.sv @@
// ============================================================================
// dssm_ram
// Single-port synchronous word store shared by both stacks, registered read.
// ============================================================================
`default_nettype none

module dssm_ram (
  input  wire logic                      clk,
  input  wire dssm_pkg::mem_req_t        req,
  output logic [dssm_pkg::DATA_W-1:0]    rdata
);
  import dssm_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH_C];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

`default_nettype wire

@@ sv/dssm_ctrl.sv @@
// ============================================================================
// dssm_ctrl
// Stack pointers, operation decode, handshake sequencing and result register.
// ============================================================================
`default_nettype none

module dssm_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // Input item
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  func,
  input  wire logic [1:0]                  stack_num,
  input  wire logic [dssm_pkg::DATA_W-1:0] push_value,
  // Result item
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output dssm_pkg::status_t                status,
  output logic [dssm_pkg::DATA_W-1:0]      read_data,
  output logic [dssm_pkg::FREE_W-1:0]      free_slots,
  // Store interface
  output dssm_pkg::mem_req_t               req,
  input  wire logic [dssm_pkg::DATA_W-1:0] rdata
);
  import dssm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LOAD = 2'b10
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  lower_count;
  logic [CNT_W-1:0]  upper_count;
  logic [CNT_W-1:0]  lower_count_next;
  logic [CNT_W-1:0]  upper_count_next;
  logic [CNT_W-1:0]  used;
  logic [CNT_W-1:0]  free_count;
  status_t           dec_status;
  logic              dec_rd;
  status_t           pend_status;
  logic              pend_rd;
  logic              accept;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign used     = lower_count + upper_count;

  // Decode the operation against the current stack depths.
  always_comb begin
    dec_status       = ST_OK;
    dec_rd           = 1'b0;
    lower_count_next = lower_count;
    upper_count_next = upper_count;
    req.we           = 1'b0;
    req.re           = 1'b0;
    req.addr         = '0;
    req.wdata        = push_value;
    unique case (func) inside
      OP_PUSH: begin
        if (used == CNT_W'(DEPTH_C)) begin
          dec_status = ST_FULL;
        end else if (stack_num == SEL_LOWER) begin
          req.we           = accept;
          req.addr         = lower_count[ADDR_W-1:0];
          lower_count_next = lower_count + 1'b1;
        end else if (stack_num == SEL_UPPER) begin
          req.we           = accept;
          req.addr         = ADDR_W'(CNT_W'(DEPTH_C - 1) - upper_count);
          upper_count_next = upper_count + 1'b1;
        end else begin
          dec_status = ST_INVALID;
        end
      end
      OP_POP, OP_PEEK: begin
        if (stack_num == SEL_LOWER) begin
          if (lower_count == '0) begin
            dec_status = ST_EMPTY;
          end else begin
            dec_rd   = 1'b1;
            req.re   = accept;
            req.addr = ADDR_W'(lower_count - 1'b1);
            if (func == OP_POP) begin
              lower_count_next = lower_count - 1'b1;
            end
          end
        end else if (stack_num == SEL_UPPER) begin
          if (upper_count == '0) begin
            dec_status = ST_EMPTY;
          end else begin
            dec_rd   = 1'b1;
            req.re   = accept;
            req.addr = ADDR_W'(CNT_W'(DEPTH_C) - upper_count);
            if (func == OP_POP) begin
              upper_count_next = upper_count - 1'b1;
            end
          end
        end else begin
          dec_status = ST_INVALID;
        end
      end
      default: begin
        dec_status = ST_INVALID;
      end
    endcase
  end

  // Sequencer and stack depths.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      lower_count <= '0;
      upper_count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state       <= S_LOAD;
            lower_count <= lower_count_next;
            upper_count <= upper_count_next;
          end
        end
        S_LOAD: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Status of the item in flight, held while the store read completes.
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status <= dec_status;
      pend_rd     <= dec_rd;
    end
  end

  // Depths are already updated when the result is loaded.
  assign free_count = CNT_W'(DEPTH_C) - lower_count - upper_count;

  // Result register: valid flag is control, the payload needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_LOAD) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      status     <= pend_status;
      read_data  <= pend_rd ? rdata : '0;
      free_slots <= FREE_W'(free_count);
    end
  end

endmodule

`default_nettype wire

@@ sv/dual_stack_shared_memory_core.sv @@
// ============================================================================
// dual_stack_shared_memory_core
// Two stacks kept in one shared word store, growing towards each other.
// ============================================================================
// Usage:
//   The slave channel takes one item per operation: push, pop or peek on the
//   lower stack (number 1, growing up from address 0) or the upper stack
//   (number 2, growing down from the top address). The master channel gives
//   exactly one result item per input item: a status, the word read (zero
//   unless a pop or peek succeeded) and the free words left afterwards.
//   An accepted item is first read from the store into its registered read
//   port and then loaded into the result register. The block takes no new
//   item while one is in flight: s_tready stays low until the result
//   register has been loaded.
//   A finished result waits in the output register; a new item is taken in
//   the same cycle in which that result is handed over.
//   Reset (rst, synchronous) empties both stacks and clears the output
//   valid. The store itself is not cleared; no access reads an unwritten
//   word. While the receiver stalls, the result holds and s_tready is low.
// ============================================================================
`default_nettype none

module dual_stack_shared_memory_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [1:0] func, [3:2] stack_num, [35:4] push_value, [39:36] zero
  input  wire logic [39:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [1:0] status, [33:2] read_data, [38:34] free_slots, [39] zero
  output logic [39:0]      m_tdata
);
  import dssm_pkg::*;

  mem_req_t           req;
  logic [DATA_W-1:0]  rdata;
  status_t            status;
  logic [DATA_W-1:0]  read_data;
  logic [FREE_W-1:0]  free_slots;

  // Pointer logic and result register.
  dssm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .func       (s_tdata[1:0]),
    .stack_num  (s_tdata[3:2]),
    .push_value (s_tdata[35:4]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .status     (status),
    .read_data  (read_data),
    .free_slots (free_slots),
    .req        (req),
    .rdata      (rdata)
  );

  // Shared word store.
  dssm_ram u_ram (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  // Pack the result item.
  assign m_tdata = {1'b0, free_slots, read_data, status};

endmodule

`default_nettype wire

@@ sv/dssm_checker.sv @@
// ============================================================================
// dssm_checker
// Port-level checks on the dual stack shared memory core, bound to the top.
// ============================================================================
`default_nettype none

module dssm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [39:0] s_tdata,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata
);
  import dssm_pkg::*;

  // A stalled result item keeps its contents.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result item changed while stalled");

  // Every accepted item is followed by a valid result item.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> ##2 m_tvalid)
    else $error("result item missing after accept");

  // One item at a time: no accept right after an accept.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item accepted while another was in flight");

  // Failed operations return no data.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] != ST_OK) |-> m_tdata[33:2] == '0)
    else $error("data returned with a failing status");

  // Free words never exceed the store size.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (DEPTH_C < 32) |-> m_tdata[38:34] <= FREE_W'(DEPTH_C))
    else $error("free word count out of range");

  logic unused_in;
  assign unused_in = ^s_tdata;

endmodule

bind dual_stack_shared_memory_core dssm_checker u_dssm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
